// ----- rtl/bcld_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the button click and long-press detector.
// Used by bcld_regs, button_click_longpress_detector_top and both bench files; no dependencies.
package bcld_pkg;

    localparam int LIMIT_BITS = 16;
    localparam int EXTRA_BITS = 3;
    localparam int KIND_BITS  = 2;
    localparam int COUNT_OUT_BITS = 4;
    localparam int ADDR_BITS  = 4;
    localparam int DATA_BITS  = 32;

    // Register indexes on the configuration port (byte address is 4 * index).
    localparam logic [1:0] REG_CLICK_GAP  = 2'd0;
    localparam logic [1:0] REG_MAX_EXTRA  = 2'd1;
    localparam logic [1:0] REG_LONG_PRESS = 2'd2;
    localparam logic [1:0] REG_VLONG_PRESS = 2'd3;

    // Event codes reported on event_kind.
    localparam logic [KIND_BITS-1:0] KIND_CLICKS        = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_LONG          = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_VLONG         = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_UP_AFTER_LONG = 2'd3;

    typedef struct packed {
        logic [LIMIT_BITS-1:0] click_gap_ticks;
        logic [EXTRA_BITS-1:0] max_extra_clicks;
        logic [LIMIT_BITS-1:0] long_press_ticks;
        logic [LIMIT_BITS-1:0] very_long_press_ticks;
    } cfg_t;

endpackage

// ----- rtl/bcld_regs.sv -----
`timescale 1ns / 1ps
// Configuration register bank behind an APB-style port.
// Depends on bcld_pkg for the register indexes and the cfg_t struct.
module bcld_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bcld_pkg::ADDR_BITS-1:0] paddr,
    input  logic [bcld_pkg::DATA_BITS-1:0] pwdata,
    output logic [bcld_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    output bcld_pkg::cfg_t                 cfg
);

    bcld_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [1:0]     reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[3:2];
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.click_gap_ticks       <= bcld_pkg::LIMIT_BITS'(30);
            cfg_reg.max_extra_clicks      <= bcld_pkg::EXTRA_BITS'(2);
            cfg_reg.long_press_ticks      <= bcld_pkg::LIMIT_BITS'(150);
            cfg_reg.very_long_press_ticks <= bcld_pkg::LIMIT_BITS'(500);
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                bcld_pkg::REG_CLICK_GAP:
                    cfg_reg.click_gap_ticks <= pwdata[bcld_pkg::LIMIT_BITS-1:0];
                bcld_pkg::REG_MAX_EXTRA:
                    cfg_reg.max_extra_clicks <= pwdata[bcld_pkg::EXTRA_BITS-1:0];
                bcld_pkg::REG_LONG_PRESS:
                    cfg_reg.long_press_ticks <= pwdata[bcld_pkg::LIMIT_BITS-1:0];
                bcld_pkg::REG_VLONG_PRESS:
                    cfg_reg.very_long_press_ticks <= pwdata[bcld_pkg::LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            bcld_pkg::REG_CLICK_GAP:
                prdata = bcld_pkg::DATA_BITS'(cfg_reg.click_gap_ticks);
            bcld_pkg::REG_MAX_EXTRA:
                prdata = bcld_pkg::DATA_BITS'(cfg_reg.max_extra_clicks);
            bcld_pkg::REG_LONG_PRESS:
                prdata = bcld_pkg::DATA_BITS'(cfg_reg.long_press_ticks);
            bcld_pkg::REG_VLONG_PRESS:
                prdata = bcld_pkg::DATA_BITS'(cfg_reg.very_long_press_ticks);
            default:
                prdata = '0;
        endcase
    end

endmodule

// ----- rtl/button_click_longpress_detector_top.sv -----
`timescale 1ns / 1ps
// Button multi-click and long-press detector, top level.
// Depends on bcld_pkg and bcld_regs.
//
// One button sample is taken per clock: a sample is accepted whenever the
// result register is empty or its result is being taken in the same cycle,
// and any event it causes appears in the result register on the next cycle.
// The event is computed combinationally from the sample and the registered press
// state and written to the result register. Samples that cause no event
// produce no output transaction. The tick counter is COUNT_BITS wide and
// saturates at all ones, so limits above that value are never reached.
module button_click_longpress_detector_top
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bcld_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [bcld_pkg::DATA_BITS-1:0]      pwdata,
    output logic [bcld_pkg::DATA_BITS-1:0]      prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                button_pressed,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bcld_pkg::KIND_BITS-1:0]      event_kind,
    output logic [bcld_pkg::COUNT_OUT_BITS-1:0] click_count
);

    localparam int CMP_BITS = (COUNT_BITS > bcld_pkg::LIMIT_BITS) ?
                              COUNT_BITS : bcld_pkg::LIMIT_BITS;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_DOWN  = 2'd1,
        PH_LONG  = 2'd2,
        PH_VLONG = 2'd3
    } phase_t;

    bcld_pkg::cfg_t cfg;

    phase_t                              phase_reg, phase_next;
    logic                                last_level_reg, last_level_next;
    logic [COUNT_BITS-1:0]               tick_count_reg, tick_count_next;
    logic [bcld_pkg::EXTRA_BITS-1:0]     extra_reg, extra_next;
    logic                                out_valid_reg, out_valid_next;
    logic [bcld_pkg::KIND_BITS-1:0]      kind_reg, kind_next;
    logic [bcld_pkg::COUNT_OUT_BITS-1:0] count_reg, count_next;

    logic                  accept;
    logic [COUNT_BITS-1:0] tick_inc;
    logic [CMP_BITS-1:0]   tick_cmp;

    bcld_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_ready    = !out_valid_reg || out_ready;
    assign accept      = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign event_kind  = kind_reg;
    assign click_count = count_reg;

    assign tick_inc = (&tick_count_reg) ? tick_count_reg
                                        : tick_count_reg + COUNT_BITS'(1);
    assign tick_cmp = CMP_BITS'(tick_inc);

    always_comb
    begin
        phase_next      = phase_reg;
        last_level_next = last_level_reg;
        tick_count_next = tick_count_reg;
        extra_next      = extra_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        kind_next       = kind_reg;
        count_next      = count_reg;

        if (accept)
        begin
            last_level_next = button_pressed;
            if (button_pressed != last_level_reg)
            begin
                if (!button_pressed)
                begin
                    // Release edge: only a held press ends the gesture here.
                    if (phase_reg == PH_LONG)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = bcld_pkg::KIND_UP_AFTER_LONG;
                        count_next     = '0;
                    end
                    if (phase_reg == PH_LONG || phase_reg == PH_VLONG)
                    begin
                        phase_next      = PH_IDLE;
                        tick_count_next = '0;
                        extra_next      = '0;
                    end
                end
                else
                begin
                    tick_count_next = '0;
                    if (phase_reg == PH_IDLE)
                        phase_next = PH_DOWN;
                    else if (phase_reg == PH_DOWN && !(&extra_reg))
                        extra_next = extra_reg + bcld_pkg::EXTRA_BITS'(1);
                end
            end
            else
            begin
                tick_count_next = tick_inc;
                if (!button_pressed)
                begin
                    if (phase_reg == PH_DOWN &&
                        (tick_cmp >= CMP_BITS'(cfg.click_gap_ticks) ||
                         extra_reg >= cfg.max_extra_clicks))
                    begin
                        out_valid_next  = 1'b1;
                        kind_next       = bcld_pkg::KIND_CLICKS;
                        count_next      = bcld_pkg::COUNT_OUT_BITS'(extra_reg) +
                                          bcld_pkg::COUNT_OUT_BITS'(1);
                        phase_next      = PH_IDLE;
                        tick_count_next = '0;
                        extra_next      = '0;
                    end
                end
                else if (phase_reg == PH_DOWN)
                begin
                    if (tick_cmp >= CMP_BITS'(cfg.long_press_ticks))
                    begin
                        phase_next     = PH_LONG;
                        out_valid_next = 1'b1;
                        kind_next      = bcld_pkg::KIND_LONG;
                        count_next     = '0;
                    end
                end
                else if (phase_reg == PH_LONG)
                begin
                    if (tick_cmp >= CMP_BITS'(cfg.very_long_press_ticks))
                    begin
                        phase_next     = PH_VLONG;
                        out_valid_next = 1'b1;
                        kind_next      = bcld_pkg::KIND_VLONG;
                        count_next     = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            last_level_reg <= 1'b0;
            tick_count_reg <= '0;
            extra_reg      <= '0;
            out_valid_reg  <= 1'b0;
            kind_reg       <= '0;
            count_reg      <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            last_level_reg <= last_level_next;
            tick_count_reg <= tick_count_next;
            extra_reg      <= extra_next;
            out_valid_reg  <= out_valid_next;
            kind_reg       <= kind_next;
            count_reg      <= count_next;
        end
    end

    // A new result can only appear as the consequence of an accepted sample.
    a_result_from_sample: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result appeared without an accepted sample");

    // Only multi-click results carry a press count.
    a_count_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((event_kind == bcld_pkg::KIND_CLICKS) == (click_count != '0)))
        else $error("click count inconsistent with event kind");

    // An idle detector holds no pending extra presses.
    a_idle_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (extra_reg == '0))
        else $error("extra presses pending while idle");

    // The held phases are only reachable while the button is down.
    a_held_level: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LONG || phase_reg == PH_VLONG) |-> last_level_reg)
        else $error("long press phase with button released");

endmodule

// ----- bench/bcld_event_checker.sv -----
`timescale 1ns / 1ps
// Event checker for the button click and long-press detector: predicts and compares events.
// Depends on bcld_pkg; watches the configuration port and both streaming channels.
module bcld_event_checker
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [bcld_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [bcld_pkg::DATA_BITS-1:0]      pwdata,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                button_pressed,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [bcld_pkg::KIND_BITS-1:0]      event_kind,
    input  logic [bcld_pkg::COUNT_OUT_BITS-1:0] click_count,
    output int                                  mismatches,
    output int                                  awaited
);

    import bcld_pkg::*;

    typedef enum logic [1:0] {
        PHASE_IDLE,
        PHASE_DOWN,
        PHASE_LONG,
        PHASE_VLONG
    } press_phase_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]      kind;
        logic [COUNT_OUT_BITS-1:0] presses;
    } button_event_t;

    cfg_t                  limits;
    logic                  level_seen;
    press_phase_t          phase;
    logic [COUNT_BITS-1:0] ticks;
    logic [EXTRA_BITS-1:0] extra_presses;
    button_event_t         pending_events[$];

    function automatic void clear_gesture();
        ticks         = '0;
        extra_presses = '0;
        phase         = PHASE_IDLE;
    endfunction

    // Advances the detector by one sample; returns 1 when the sample raises an event.
    function automatic bit detect_event(input logic level, output button_event_t ev);
        ev = '0;
        if (level != level_seen)
        begin
            level_seen = level;
            if (!level)
            begin
                if (phase == PHASE_LONG || phase == PHASE_VLONG)
                begin
                    // Letting go after a very long hold reports nothing.
                    if (phase == PHASE_LONG)
                    begin
                        ev.kind = KIND_UP_AFTER_LONG;
                        clear_gesture();
                        return 1'b1;
                    end
                    clear_gesture();
                end
                return 1'b0;
            end
            ticks = '0;
            if (phase == PHASE_IDLE)
                phase = PHASE_DOWN;
            else if (phase == PHASE_DOWN && extra_presses != '1)
                extra_presses = extra_presses + 1'b1;
            return 1'b0;
        end

        if (ticks != '1)
            ticks = ticks + 1'b1;

        if (!level)
        begin
            if (phase == PHASE_DOWN && (ticks >= limits.click_gap_ticks ||
                                        extra_presses >= limits.max_extra_clicks))
            begin
                ev.kind    = KIND_CLICKS;
                ev.presses = COUNT_OUT_BITS'(extra_presses) + 1'b1;
                clear_gesture();
                return 1'b1;
            end
            return 1'b0;
        end

        if (phase == PHASE_DOWN && ticks >= limits.long_press_ticks)
        begin
            phase   = PHASE_LONG;
            ev.kind = KIND_LONG;
            return 1'b1;
        end
        if (phase == PHASE_LONG && ticks >= limits.very_long_press_ticks)
        begin
            phase   = PHASE_VLONG;
            ev.kind = KIND_VLONG;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        button_event_t ev;
        if (!rst_n)
        begin
            limits.click_gap_ticks       = 16'd30;
            limits.max_extra_clicks      = 3'd2;
            limits.long_press_ticks      = 16'd150;
            limits.very_long_press_ticks = 16'd500;
            level_seen = 1'b0;
            clear_gesture();
            pending_events.delete();
            mismatches = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_events.size() == 0)
                begin
                    $display("%0t: unexpected event: kind %0d count %0d, expected none",
                             $time, event_kind, click_count);
                    mismatches++;
                end
                else
                begin
                    ev = pending_events.pop_front();
                    if (event_kind !== ev.kind || click_count !== ev.presses)
                    begin
                        $display("%0t: event mismatch: expected kind %0d count %0d, got kind %0d count %0d",
                                 $time, ev.kind, ev.presses, event_kind, click_count);
                        mismatches++;
                    end
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_CLICK_GAP:   limits.click_gap_ticks       = pwdata[LIMIT_BITS-1:0];
                    REG_MAX_EXTRA:   limits.max_extra_clicks      = pwdata[EXTRA_BITS-1:0];
                    REG_LONG_PRESS:  limits.long_press_ticks      = pwdata[LIMIT_BITS-1:0];
                    REG_VLONG_PRESS: limits.very_long_press_ticks = pwdata[LIMIT_BITS-1:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                if (detect_event(button_pressed, ev))
                    pending_events.push_back(ev);
            end
        end
        awaited = pending_events.size();
    end

endmodule

// ----- bench/button_click_longpress_detector_top_test.sv -----
`timescale 1ns / 1ps
// Testbench top for the button click and long-press detector: clock, reset, stimulus, verdict.
// Depends on bcld_pkg, button_click_longpress_detector_top and bcld_event_checker.
module button_click_longpress_detector_top_test;

    import bcld_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int SEGMENT_ITEMS = 90;

    logic                      clk            = 1'b0;
    logic                      rst_n          = 1'b0;
    logic                      psel           = 1'b0;
    logic                      penable        = 1'b0;
    logic                      pwrite         = 1'b0;
    logic [ADDR_BITS-1:0]      paddr          = '0;
    logic [DATA_BITS-1:0]      pwdata         = '0;
    logic [DATA_BITS-1:0]      prdata;
    logic                      pready;
    logic                      in_valid       = 1'b0;
    logic                      in_ready;
    logic                      button_pressed = 1'b0;
    logic                      out_valid;
    logic                      out_ready      = 1'b0;
    logic [KIND_BITS-1:0]      event_kind;
    logic [COUNT_OUT_BITS-1:0] click_count;

    int mismatches;
    int awaited;

    int send_gap_pct = 0;
    int stall_pct    = 0;
    int hold_len     = 0;
    int items_sent   = 0;
    int cycle_count  = 0;

    // Shadow of the programmed limits, used only to shape gestures.
    int gap_cur   = 30;
    int long_cur  = 150;
    int vlong_cur = 500;

    always #4 clk = ~clk;

    button_click_longpress_detector_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .button_pressed (button_pressed),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_kind     (event_kind),
        .click_count    (click_count)
    );

    bcld_event_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .button_pressed (button_pressed),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_kind     (event_kind),
        .click_count    (click_count),
        .mismatches     (mismatches),
        .awaited        (awaited)
    );

    initial
    begin : watchdog
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off whenever hold_len is set.
    initial
    begin : receiver
        int held_cycles;
        held_cycles = 0;
        forever
        begin
            @(negedge clk);
            if (hold_len != 0 && held_cycles < hold_len)
            begin
                out_ready <= 1'b0;
                held_cycles++;
            end
            else
            begin
                if (hold_len == 0)
                    held_cycles = 0;
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_level(input logic level);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid       <= 1'b0;
            button_pressed <= 1'($urandom_range(1));
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        button_pressed <= level;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_run(input logic level, input int n);
        repeat (n)
            send_level(level);
    endtask

    // Waits until every expected event has arrived and the block has gone quiet.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_BITS'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input int gap, input int extra, input int long_ticks,
                             input int vlong_ticks);
        drain();
        write_reg(REG_CLICK_GAP, gap);
        write_reg(REG_MAX_EXTRA, extra);
        write_reg(REG_LONG_PRESS, long_ticks);
        write_reg(REG_VLONG_PRESS, vlong_ticks);
        gap_cur   = gap;
        long_cur  = long_ticks;
        vlong_cur = vlong_ticks;
    endtask

    function automatic int pick_limit(input int top);
        if ($urandom_range(9) == 0)
            return 0;
        return $urandom_range(1, top);
    endfunction

    // A run of presses with random hold and gap times; the final release may be
    // too short for the multi-click to be reported.
    task automatic gesture();
        int presses;
        int hold;
        int gap_len;
        int i;
        presses = $urandom_range(1, 9);
        for (i = 0; i < presses; i++)
        begin
            if ($urandom_range(9) < 7)
                hold = $urandom_range(1, 4);
            else
                hold = $urandom_range(1, long_cur + vlong_cur + 2);
            send_run(1'b1, hold);
            if (i == presses - 1)
                gap_len = $urandom_range(1, gap_cur + 3);
            else
                gap_len = $urandom_range(1, gap_cur + 1);
            send_run(1'b0, gap_len);
        end
    endtask

    task automatic random_phase(input int sender_pct, input int receiver_pct,
                                input bit long_hold);
        int target;
        int seg;
        int n;
        for (seg = 0; seg < 3; seg++)
        begin
            configure(pick_limit(24), $urandom_range(0, 7), pick_limit(40), pick_limit(60));
            send_gap_pct = sender_pct;
            stall_pct    = receiver_pct;
            if (long_hold && seg == 0)
                hold_len = 300;
            target = items_sent + SEGMENT_ITEMS;
            while (items_sent < target)
            begin
                if ($urandom_range(4) != 0)
                    gesture();
                else
                begin
                    n = $urandom_range(1, 8);
                    repeat (n)
                        send_level(1'($urandom_range(1)));
                end
            end
            hold_len = 0;
        end
        send_gap_pct = 0;
        stall_pct    = 0;
    endtask

    initial
    begin : stimulus
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Long and very long holds, release after each, and a two-press click.
        configure(3, 7, 4, 6);
        send_run(1'b0, 2);
        send_run(1'b1, 7);
        send_run(1'b0, 2);
        send_run(1'b1, 5);
        send_run(1'b0, 1);
        send_run(1'b1, 1);
        send_run(1'b0, 1);
        send_run(1'b1, 1);
        send_run(1'b0, 4);

        // Very long limit below the long one; no extra presses allowed.
        configure(65535, 0, 2, 1);
        send_run(1'b1, 4);
        send_run(1'b0, 1);
        send_run(1'b1, 1);
        send_run(1'b0, 2);

        // Top hold limits that a short hold never reaches; a zero gap ends the click at once.
        configure(0, 7, 65535, 65535);
        send_run(1'b1, 40);
        send_run(1'b0, 3);
        send_run(1'b1, 1);
        send_run(1'b0, 2);

        random_phase(0, 0, 1'b0);
        random_phase(46, 0, 1'b0);
        random_phase(0, 46, 1'b1);
        random_phase(12, 12, 1'b0);

        drain();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/bcld_pkg.sv
rtl/bcld_regs.sv
rtl/button_click_longpress_detector_top.sv
bench/bcld_event_checker.sv
bench/button_click_longpress_detector_top_test.sv
